### rtl/triac_phase_angle_heater_control_assert.svh
// Assertion macros for the triac phase-angle heater controller
`ifndef TRIAC_PHASE_ANGLE_HEATER_CONTROL_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_HEATER_CONTROL_ASSERT_SVH

// same-cycle implication; the consequent may carry a fixed ## delay
`define TPAHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("tpahc: implication check failed");

// next-cycle implication
`define TPAHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpahc: next-cycle check failed");

`endif

### rtl/tpahc_pkg.sv
// Types, widths and constants shared by the heater controller modules
package tpahc_pkg;

   localparam int DELAY_BITS     = 21;
   localparam int ADC_BITS       = 10;
   localparam int INTERVAL_BITS  = 8;
   localparam int PULSE_BITS     = 16;
   localparam int GAIN_BITS      = 16;
   localparam int REF_BITS       = 16;
   localparam int SLOPE_BITS     = 16;
   localparam int OFFSET_BITS    = 21;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 21;

   localparam int SCALED_BITS = ADC_BITS + SLOPE_BITS;
   localparam int TEMP_BITS   = SCALED_BITS + 2;
   localparam int ERR_BITS    = TEMP_BITS + 1;
   localparam int PROD_BITS   = ERR_BITS + GAIN_BITS + 1;
   localparam int QUOT_BITS   = PROD_BITS - FRAC_BITS;
   localparam int CMP_BITS    = (QUOT_BITS > DELAY_BITS) ? QUOT_BITS : DELAY_BITS;

   localparam logic [INTERVAL_BITS-1:0] SAMPLE_INTERVAL_RESET = INTERVAL_BITS'(50);
   localparam logic [PULSE_BITS-1:0]    PULSE_WIDTH_RESET     = PULSE_BITS'(50000);
   localparam logic [DELAY_BITS-1:0]    DELAY_MIN_RESET       = DELAY_BITS'(35000);
   localparam logic [DELAY_BITS-1:0]    DELAY_MAX_RESET       = DELAY_BITS'(1901000);
   localparam logic [GAIN_BITS-1:0]     LOOP_GAIN_RESET       = GAIN_BITS'(9110);
   localparam logic [REF_BITS-1:0]      REFERENCE_RESET       = REF_BITS'(14080);
   localparam logic [SLOPE_BITS-1:0]    SLOPE_RESET           = SLOPE_BITS'(20119);
   localparam logic signed [OFFSET_BITS-1:0] OFFSET_RESET     = -OFFSET_BITS'(103154);
   localparam logic [INTERVAL_BITS-1:0] HALF_CYCLE_FULL       = '1;

   typedef enum logic [1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_ZERO_CROSS = 2'd1,
      FUNC_SAMPLE     = 2'd2,
      FUNC_NONE       = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLE_INTERVAL = 3'd0,
      CSR_PULSE_WIDTH     = 3'd1,
      CSR_DELAY_MIN       = 3'd2,
      CSR_DELAY_MAX       = 3'd3,
      CSR_LOOP_GAIN       = 3'd4,
      CSR_REFERENCE       = 3'd5,
      CSR_SLOPE           = 3'd6,
      CSR_OFFSET          = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [ADC_BITS-1:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic                  trigger_on;
      logic                  adc_start;
      logic [DELAY_BITS-1:0] fire_delay;
   } rsp_type;

   typedef struct packed {
      logic take_item;
      logic form_error;
      logic form_product;
      logic write_delay;
      logic cfg_write;
      logic push;
   } ctrl_cmd_type;

endpackage

### rtl/tpahc_rsp_queue.sv
// Two-entry result queue between the datapath and the result channel
module tpahc_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tpahc_pkg::rsp_type push_data,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpahc_pkg::rsp_type rsp_data
);
   import tpahc_pkg::*;

   rsp_type    entry_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [1:0] wr_slot;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign room      = (count_ff != 2'd2);
   assign rsp_data  = entry_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_slot   = count_ff - {1'b0, pop};

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !wr_slot[0]) begin
         entry_ff[0] <= push_data;
      end else if (pop) begin
         entry_ff[0] <= entry_ff[1];
      end
      if (push && wr_slot[0]) begin
         entry_ff[1] <= push_data;
      end
   end

endmodule

### rtl/tpahc_ctrl.sv
// Controller state machine: item acceptance and sample computation sequencing
module tpahc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_func,
   output logic                   req_stall,
   input  logic                   queue_room,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   output tpahc_pkg::ctrl_cmd_type cmd
);
   import tpahc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ERROR = 4'b0010,
      S_GAIN  = 4'b0100,
      S_CLAMP = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           take;
   logic           is_sample;

   assign req_stall = !((state_ff == S_IDLE) && queue_room);
   assign csr_ready = (state_ff == S_IDLE);
   assign take      = req_valid && !req_stall;
   assign is_sample = (req_func == FUNC_SAMPLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take && is_sample) begin
               state_in = S_ERROR;
            end
         end
         S_ERROR: state_in = S_GAIN;
         S_GAIN:  state_in = S_CLAMP;
         S_CLAMP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.take_item    = take;
      cmd.form_error   = (state_ff == S_ERROR);
      cmd.form_product = (state_ff == S_GAIN);
      cmd.write_delay  = (state_ff == S_CLAMP);
      cmd.cfg_write    = csr_valid && csr_ready;
      cmd.push         = (take && !is_sample) || (state_ff == S_CLAMP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/tpahc_dpath.sv
// Datapath: settings, timing counters and the proportional delay computation
module tpahc_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tpahc_pkg::ctrl_cmd_type               cmd,
   input  tpahc_pkg::req_type                    req_data,
   input  logic [tpahc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tpahc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output tpahc_pkg::rsp_type                    push_data
);
   import tpahc_pkg::*;

   logic [INTERVAL_BITS-1:0]      interval_ff;
   logic [PULSE_BITS-1:0]         pulse_width_ff;
   logic [DELAY_BITS-1:0]         delay_min_ff;
   logic [DELAY_BITS-1:0]         delay_max_ff;
   logic [GAIN_BITS-1:0]          gain_ff;
   logic [REF_BITS-1:0]           reference_ff;
   logic [SLOPE_BITS-1:0]         slope_ff;
   logic signed [OFFSET_BITS-1:0] offset_ff;

   logic [INTERVAL_BITS-1:0] half_cycle_ff, half_cycle_in;
   logic [DELAY_BITS-1:0]    delay_value_ff;
   logic [DELAY_BITS-1:0]    delay_count_ff, delay_count_in;
   logic                     delay_run_ff, delay_run_in;
   logic [PULSE_BITS-1:0]    pulse_count_ff, pulse_count_in;
   logic                     pulse_run_ff, pulse_run_in;
   logic                     trigger_ff, trigger_in;
   logic                     start;

   logic [SCALED_BITS-1:0]       scaled_ff, scaled_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic signed [ERR_BITS-1:0]   temp_ext, ref_ext;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [GAIN_BITS:0]    gain_s;
   logic [CMP_BITS-1:0]          quot_c, max_c, min_c;
   logic [DELAY_BITS-1:0]        clamp_delay;

   // sample path: scale, error, gain, clamp
   assign scaled_in = SCALED_BITS'(req_data.adc_sample) * SCALED_BITS'(slope_ff);
   assign temp_ext  = $signed({{(ERR_BITS-SCALED_BITS){1'b0}}, scaled_ff})
                    + $signed({{(ERR_BITS-OFFSET_BITS){offset_ff[OFFSET_BITS-1]}}, offset_ff});
   assign ref_ext   = $signed(ERR_BITS'({reference_ff, 8'h00}));
   assign err_in    = ref_ext - temp_ext;
   assign gain_s    = $signed({1'b0, gain_ff});
   assign prod_in   = gain_s * err_ff;
   assign quot_c    = CMP_BITS'(prod_ff[PROD_BITS-1:FRAC_BITS]);
   assign max_c     = CMP_BITS'(delay_max_ff);
   assign min_c     = CMP_BITS'(delay_min_ff);

   always_comb begin
      if (prod_ff[PROD_BITS-1] || (prod_ff == '0)) begin
         clamp_delay = delay_max_ff;
      end else if (quot_c > max_c) begin
         clamp_delay = delay_max_ff;
      end else if (quot_c < min_c) begin
         clamp_delay = delay_min_ff;
      end else begin
         clamp_delay = DELAY_BITS'(quot_c);
      end
   end

   // timing state for the item on the request port
   always_comb begin
      half_cycle_in  = half_cycle_ff;
      delay_count_in = delay_count_ff;
      delay_run_in   = delay_run_ff;
      pulse_count_in = pulse_count_ff;
      pulse_run_in   = pulse_run_ff;
      trigger_in     = trigger_ff;
      start          = 1'b0;
      unique case (req_data.func) inside
         FUNC_TICK: begin
            if (half_cycle_ff >= interval_ff) begin
               half_cycle_in = '0;
               start         = 1'b1;
            end
            if (pulse_run_ff) begin
               if (pulse_count_ff != '0) begin
                  pulse_count_in = pulse_count_ff - 1'b1;
               end
               if (pulse_count_ff <= PULSE_BITS'(1)) begin
                  pulse_run_in = 1'b0;
                  trigger_in   = 1'b0;
               end
            end
            if (delay_run_ff) begin
               if (delay_count_ff != '0) begin
                  delay_count_in = delay_count_ff - 1'b1;
               end
               if (delay_count_ff <= DELAY_BITS'(1)) begin
                  delay_run_in   = 1'b0;
                  trigger_in     = 1'b1;
                  pulse_count_in = pulse_width_ff;
                  pulse_run_in   = 1'b1;
               end
            end
         end
         FUNC_ZERO_CROSS: begin
            if (half_cycle_ff != HALF_CYCLE_FULL) begin
               half_cycle_in = half_cycle_ff + 1'b1;
            end
            delay_count_in = delay_value_ff;
            delay_run_in   = 1'b1;
         end
         FUNC_SAMPLE, FUNC_NONE: begin
            start = 1'b0;
         end
         default: begin
            start = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.write_delay) begin
         push_data.trigger_on = trigger_ff;
         push_data.adc_start  = 1'b0;
         push_data.fire_delay = clamp_delay;
      end else begin
         push_data.trigger_on = trigger_in;
         push_data.adc_start  = start;
         push_data.fire_delay = delay_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= SAMPLE_INTERVAL_RESET;
         pulse_width_ff <= PULSE_WIDTH_RESET;
         delay_min_ff   <= DELAY_MIN_RESET;
         delay_max_ff   <= DELAY_MAX_RESET;
         gain_ff        <= LOOP_GAIN_RESET;
         reference_ff   <= REFERENCE_RESET;
         slope_ff       <= SLOPE_RESET;
         offset_ff      <= OFFSET_RESET;
      end else if (cmd.cfg_write) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: interval_ff    <= csr_data[INTERVAL_BITS-1:0];
            CSR_PULSE_WIDTH:     pulse_width_ff <= csr_data[PULSE_BITS-1:0];
            CSR_DELAY_MIN:       delay_min_ff   <= DELAY_BITS'(csr_data);
            CSR_DELAY_MAX:       delay_max_ff   <= DELAY_BITS'(csr_data);
            CSR_LOOP_GAIN:       gain_ff        <= csr_data[GAIN_BITS-1:0];
            CSR_REFERENCE:       reference_ff   <= csr_data[REF_BITS-1:0];
            CSR_SLOPE:           slope_ff       <= csr_data[SLOPE_BITS-1:0];
            CSR_OFFSET:          offset_ff      <= $signed(csr_data[OFFSET_BITS-1:0]);
            default:             interval_ff    <= interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_cycle_ff  <= '0;
         delay_value_ff <= '0;
         delay_count_ff <= '0;
         delay_run_ff   <= 1'b0;
         pulse_count_ff <= '0;
         pulse_run_ff   <= 1'b0;
         trigger_ff     <= 1'b0;
      end else begin
         if (cmd.take_item) begin
            half_cycle_ff  <= half_cycle_in;
            delay_count_ff <= delay_count_in;
            delay_run_ff   <= delay_run_in;
            pulse_count_ff <= pulse_count_in;
            pulse_run_ff   <= pulse_run_in;
            trigger_ff     <= trigger_in;
         end
         if (cmd.write_delay) begin
            delay_value_ff <= clamp_delay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         scaled_ff <= scaled_in;
      end
      if (cmd.form_error) begin
         err_ff <= err_in;
      end
      if (cmd.form_product) begin
         prod_ff <= prod_in;
      end
   end

endmodule

### rtl/triac_phase_angle_heater_control.sv
// Top level of the triac phase-angle heater controller
// Tick, zero-crossing and unused-code items need no extra steps and may follow
// back to back; the datapath keeps the phase counters and the trigger level.
// An ADC sample item runs in steps: the accept cycle forms adc_sample times
// slope, then three datapath steps (temperature error, gain multiply, clamp)
// run in turn while req_stall stays high, since the multipliers are registered
// one after the other. Results leave through a two-item queue, so the input
// keeps flowing while one result waits on rsp_stall and stalls once two wait.
// Settings are written through csr_*; csr_ready is low only while a sample is
// in progress.
module triac_phase_angle_heater_control (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tpahc_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tpahc_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tpahc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tpahc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import tpahc_pkg::*;

   `include "triac_phase_angle_heater_control_assert.svh"

   ctrl_cmd_type ctrl_cmd;
   rsp_type      push_data;
   logic         q_room;
   logic         sample_take;

   tpahc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_func   (req_data.func),
      .req_stall  (req_stall),
      .queue_room (q_room),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (ctrl_cmd)
   );

   tpahc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl_cmd),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push_data (push_data)
   );

   tpahc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ctrl_cmd.push),
      .push_data (push_data),
      .room      (q_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign sample_take = ctrl_cmd.take_item && (req_data.func == FUNC_SAMPLE);

   `TPAHC_ASSERT_IMPLY(a_push_has_room, clock, reset, ctrl_cmd.push, q_room)
   `TPAHC_ASSERT_NEXT(a_sample_blocks_input, clock, reset, sample_take, req_stall)
   `TPAHC_ASSERT_IMPLY(a_sample_result_latency, clock, reset, sample_take, ##3 ctrl_cmd.push)

endmodule
